[src/pors_pkg.sv]
// Package for the photon orbit RK4 stepper: word widths, fixed-point constants,
// controller types and the saturating helpers shared by the datapath units.
// Depends on nothing.
package pors_pkg;

  localparam int WORD_BITS    = 48;
  localparam int FRAC_BITS    = 36;
  localparam int FINE_DIVISOR = 25;
  localparam int SUM_DIVISOR  = 6;
  localparam int SUM_ROUND    = SUM_DIVISOR / 2;

  localparam int HALF_BITS = (WORD_BITS + 1) / 2;
  localparam int PROD_BITS = 2 * WORD_BITS;

  localparam int DIV_DIGITS   = 4;
  localparam int DIV_STEPS    = (WORD_BITS + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int DIV_PAD_BITS = DIV_STEPS * DIV_DIGITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam int DIV_MAX      = (FINE_DIVISOR > SUM_DIVISOR) ? FINE_DIVISOR : SUM_DIVISOR;
  localparam int DIVR_BITS    = $clog2(DIV_MAX) + 1;

  localparam int IN_DATA_BITS  = ((4 * WORD_BITS - 1) + 7) / 8 * 8;
  localparam int OUT_DATA_BITS = ((5 * WORD_BITS - 1) + 7) / 8 * 8;
  localparam int IN_U_LSB      = 0;
  localparam int IN_DU_LSB     = WORD_BITS;
  localparam int IN_PHI_LSB    = 2 * WORD_BITS;
  localparam int IN_PEAK_LSB   = 3 * WORD_BITS;

  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [WORD_BITS-1:0] mag_t;
  typedef logic        [WORD_BITS-2:0] uword_t;
  typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_STEP_ANGLE     = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_CAPTURE_LIMIT  = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_FINE_THRESHOLD = cfg_idx_t'(2);

  localparam word_t  STEP_RESET  = word_t'(-1199343);
  localparam uword_t LIMIT_RESET = uword_t'(64'd13743895347200);
  localparam uword_t THR_RESET   = uword_t'(64'd11453246123);

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS - 1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS - 1){1'b0}}});

  localparam logic [63:0] HALF_PI_Q63 = 64'hC90FDAA22168C235;
  localparam word_t HALF_PI =
    word_t'((HALF_PI_Q63 + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS));

  typedef enum logic [3:0] {
    S_IDLE,
    S_RK_INIT,
    S_MUL,
    S_MUL_WAIT,
    S_ACC_A,
    S_ACC_B,
    S_ACCUM,
    S_DIV,
    S_DIV_WAIT,
    S_DIV_USE,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    MP_KU,
    MP_SQ,
    MP_KD
  } mul_phase_e;

  typedef enum logic [1:0] {
    DP_STEP,
    DP_SUM_U,
    DP_SUM_D
  } div_phase_e;

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t half(word_t x);
    word_t t;
    t = x + word_t'({{(WORD_BITS - 1){1'b0}}, x[WORD_BITS-1]});
    return t >>> 1;
  endfunction

  function automatic mag_t magn(word_t x);
    return x[WORD_BITS-1] ? mag_t'(-x) : mag_t'(x);
  endfunction

endpackage

[src/pors_mul.sv]
// Shared fixed-point multiplier: sign-magnitude product built from four
// half-width partial products, then rounded and saturated to one word.
// Depends on pors_pkg.
module pors_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pors_pkg::word_t a_i,
  input  pors_pkg::word_t b_i,
  output logic            done_o,
  output pors_pkg::word_t prod_o
);

  localparam int Q_BITS = pors_pkg::PROD_BITS - pors_pkg::FRAC_BITS;

  logic                                busy_q, fin_q, done_q, neg_q;
  logic [1:0]                          cnt_q;
  pors_pkg::mag_t                      ma_q, mb_q;
  logic [pors_pkg::PROD_BITS-1:0]      acc_q, pp_ext;
  logic [pors_pkg::HALF_BITS-1:0]      a_part, b_part;
  logic [2*pors_pkg::HALF_BITS-1:0]    pp;
  logic [Q_BITS-1:0]                   q;
  logic [pors_pkg::WORD_BITS-1:0]      qlo;
  logic                                over;
  pors_pkg::word_t                     res, prod_q;

  always_comb begin
    a_part = cnt_q[1] ? pors_pkg::HALF_BITS'(ma_q >> pors_pkg::HALF_BITS)
                      : ma_q[pors_pkg::HALF_BITS-1:0];
    b_part = cnt_q[0] ? pors_pkg::HALF_BITS'(mb_q >> pors_pkg::HALF_BITS)
                      : mb_q[pors_pkg::HALF_BITS-1:0];
    pp = a_part * b_part;
    unique case (cnt_q)
      2'd0:       pp_ext = pors_pkg::PROD_BITS'(pp);
      2'd1, 2'd2: pp_ext = pors_pkg::PROD_BITS'(pp) << pors_pkg::HALF_BITS;
      default:    pp_ext = pors_pkg::PROD_BITS'(pp) << (2 * pors_pkg::HALF_BITS);
    endcase
  end

  always_comb begin
    q    = acc_q[pors_pkg::PROD_BITS-1:pors_pkg::FRAC_BITS];
    qlo  = q[pors_pkg::WORD_BITS-1:0];
    over = (|q[Q_BITS-1:pors_pkg::WORD_BITS]) ||
           (neg_q ? (qlo[pors_pkg::WORD_BITS-1] && (|qlo[pors_pkg::WORD_BITS-2:0]))
                  : qlo[pors_pkg::WORD_BITS-1]);
    if (over) begin
      res = neg_q ? pors_pkg::WORD_MIN : pors_pkg::WORD_MAX;
    end else begin
      res = neg_q ? pors_pkg::word_t'(-qlo) : pors_pkg::word_t'(qlo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= pors_pkg::magn(a_i);
      mb_q  <= pors_pkg::magn(b_i);
      neg_q <= a_i[pors_pkg::WORD_BITS-1] ^ b_i[pors_pkg::WORD_BITS-1];
      acc_q <= pors_pkg::PROD_BITS'(1) << (pors_pkg::FRAC_BITS - 1);
    end else if (busy_q) begin
      acc_q <= acc_q + pp_ext;
    end
    if (fin_q) begin
      prod_q <= res;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

[src/pors_div.sv]
// Shared divider for small divisors: restoring division of an unsigned word,
// four quotient bits per cycle with a narrow remainder.
// Depends on pors_pkg.
module pors_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  pors_pkg::mag_t                  dividend_i,
  input  logic [pors_pkg::DIVR_BITS-1:0]  divisor_i,
  output logic                            done_o,
  output pors_pkg::mag_t                  quot_o
);

  logic                               busy_q, done_q;
  logic [pors_pkg::DIV_CNT_BITS-1:0]  cnt_q;
  logic [pors_pkg::DIV_PAD_BITS-1:0]  num_q, quo_q, num_d, quo_d;
  logic [pors_pkg::DIVR_BITS-1:0]     rem_q, dvs_q, rem_d;

  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    for (int i = 0; i < pors_pkg::DIV_DIGITS; i++) begin
      rem_d = {rem_d[pors_pkg::DIVR_BITS-2:0], num_d[pors_pkg::DIV_PAD_BITS-1]};
      num_d = num_d << 1;
      quo_d = quo_d << 1;
      if (rem_d >= dvs_q) begin
        rem_d    = rem_d - dvs_q;
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pors_pkg::DIV_CNT_BITS'(pors_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= pors_pkg::DIV_PAD_BITS'(dividend_i);
      quo_q <= '0;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[pors_pkg::WORD_BITS-1:0];

endmodule

[src/photon_orbit_rk4_stepper_top.sv]
// Photon orbit stepper: integrates u'' = 1.5u^2 - u with classic RK4 in signed
// Q12.36, one RK4 step per advance word, with closest approach and capture tracking.
// Depends on pors_pkg, pors_mul and pors_div.
//
// The block takes one word at a time and returns exactly one word for each.
// A load word (opcode 0) or an advance word while captured or at the moment
// of capture goes straight to the output state. An advance word runs the
// four RK4 stages through one shared multiplier (three products per stage)
// and then two divisions by six on one shared divider; the fine step adds
// one more division for step_angle / 25. The input is not ready during that
// time; a finished word waits in the output register and the next word may
// be taken meanwhile. Configuration is always ready.
module photon_orbit_rk4_stepper_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // start_u, start_du, start_phi, start_peak_u, zero pad
  input  logic [pors_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  // opcode
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // inv_radius, inv_radius_slope, angle, closest_u, closest_angle, zero pad
  output logic [pors_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  // captured, fine_mode
  output logic [1:0]                            m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  pors_pkg::cfg_idx_t                    cfg_index_i,
  input  logic [pors_pkg::WORD_BITS-1:0]        cfg_data_i
);

  localparam int W = pors_pkg::WORD_BITS;

  pors_pkg::state_e     state_q, state_d;
  pors_pkg::mul_phase_e mphase_q;
  pors_pkg::div_phase_e dphase_q;
  logic [1:0]           stage_q;

  pors_pkg::word_t  step_q;
  pors_pkg::uword_t cap_q, thr_q;

  pors_pkg::word_t  u_q, du_q, phi_q, peak_ang_q;
  pors_pkg::uword_t peak_q;
  logic             fine_q, capt_q;

  pors_pkg::word_t  h_q, us_q, ds_q, ku_q, t_q, kd_q, su_q, sd_q, dq_q;
  logic             dneg_q;

  logic                             m_valid_q;
  logic [pors_pkg::OUT_DATA_BITS-1:0] m_data_q;
  logic [1:0]                       m_user_q;

  logic             in_acc, out_free, mul_start, div_start, mul_done, div_done;
  logic             capt_hit, peak_hit, fine_next;
  pors_pkg::word_t  mul_a, mul_b, mul_p, cap_s, thr_s, peak_s;
  pors_pkg::mag_t   div_num, div_quot;
  logic [pors_pkg::DIVR_BITS-1:0] div_dvs;
  logic             div_neg;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  assign cap_s     = pors_pkg::word_t'({1'b0, cap_q});
  assign thr_s     = pors_pkg::word_t'({1'b0, thr_q});
  assign peak_s    = pors_pkg::word_t'({1'b0, peak_q});
  assign capt_hit  = u_q > cap_s;
  assign peak_hit  = u_q > peak_s;
  assign fine_next = fine_q ? !(u_q < thr_s) : (u_q > thr_s);

  always_comb begin
    unique case (mphase_q)
      pors_pkg::MP_KU: begin
        mul_a = h_q;
        mul_b = ds_q;
      end
      pors_pkg::MP_SQ: begin
        mul_a = us_q;
        mul_b = us_q;
      end
      default: begin
        mul_a = h_q;
        mul_b = t_q;
      end
    endcase
  end

  always_comb begin
    unique case (dphase_q)
      pors_pkg::DP_STEP: begin
        div_num = pors_pkg::magn(step_q);
        div_dvs = pors_pkg::DIVR_BITS'(pors_pkg::FINE_DIVISOR);
        div_neg = step_q[W-1];
      end
      pors_pkg::DP_SUM_U: begin
        div_num = pors_pkg::mag_t'(pors_pkg::magn(su_q) + pors_pkg::SUM_ROUND);
        div_dvs = pors_pkg::DIVR_BITS'(pors_pkg::SUM_DIVISOR);
        div_neg = su_q[W-1];
      end
      default: begin
        div_num = pors_pkg::mag_t'(pors_pkg::magn(sd_q) + pors_pkg::SUM_ROUND);
        div_dvs = pors_pkg::DIVR_BITS'(pors_pkg::SUM_DIVISOR);
        div_neg = sd_q[W-1];
      end
    endcase
  end

  pors_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  pors_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pors_pkg::S_IDLE: begin
        if (in_acc) begin
          priority if (!s_axis_tuser || capt_q || capt_hit) begin
            state_d = pors_pkg::S_OUT;
          end else if (fine_next) begin
            state_d = pors_pkg::S_DIV;
          end else begin
            state_d = pors_pkg::S_RK_INIT;
          end
        end
      end
      pors_pkg::S_RK_INIT: state_d = pors_pkg::S_MUL;
      pors_pkg::S_MUL:     state_d = pors_pkg::S_MUL_WAIT;
      pors_pkg::S_MUL_WAIT: begin
        if (mul_done) begin
          unique case (mphase_q)
            pors_pkg::MP_KU: state_d = pors_pkg::S_MUL;
            pors_pkg::MP_SQ: state_d = pors_pkg::S_ACC_A;
            default:         state_d = pors_pkg::S_ACCUM;
          endcase
        end
      end
      pors_pkg::S_ACC_A: state_d = pors_pkg::S_ACC_B;
      pors_pkg::S_ACC_B: state_d = pors_pkg::S_MUL;
      pors_pkg::S_ACCUM: state_d = (stage_q == 2'd3) ? pors_pkg::S_DIV : pors_pkg::S_MUL;
      pors_pkg::S_DIV:   state_d = pors_pkg::S_DIV_WAIT;
      pors_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          state_d = pors_pkg::S_DIV_USE;
        end
      end
      pors_pkg::S_DIV_USE: begin
        unique case (dphase_q)
          pors_pkg::DP_STEP:  state_d = pors_pkg::S_RK_INIT;
          pors_pkg::DP_SUM_U: state_d = pors_pkg::S_DIV;
          default:            state_d = pors_pkg::S_OUT;
        endcase
      end
      pors_pkg::S_OUT: begin
        if (out_free) begin
          state_d = pors_pkg::S_IDLE;
        end
      end
      default: state_d = pors_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == pors_pkg::S_IDLE);
    mul_start     = (state_q == pors_pkg::S_MUL);
    div_start     = (state_q == pors_pkg::S_DIV);
    cfg_ready_o   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pors_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pors_pkg::STEP_RESET;
      cap_q  <= pors_pkg::LIMIT_RESET;
      thr_q  <= pors_pkg::THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pors_pkg::CFG_STEP_ANGLE:     step_q <= pors_pkg::word_t'(cfg_data_i);
        pors_pkg::CFG_CAPTURE_LIMIT:  cap_q  <= cfg_data_i[W-2:0];
        pors_pkg::CFG_FINE_THRESHOLD: thr_q  <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q        <= '0;
      du_q       <= '0;
      phi_q      <= '0;
      peak_q     <= '0;
      peak_ang_q <= '0;
      fine_q     <= 1'b0;
      capt_q     <= 1'b0;
      mphase_q   <= pors_pkg::MP_KU;
      dphase_q   <= pors_pkg::DP_STEP;
      stage_q    <= 2'd0;
    end else begin
      unique case (state_q)
        pors_pkg::S_IDLE: begin
          if (in_acc) begin
            priority if (!s_axis_tuser) begin
              u_q        <= s_axis_tdata[pors_pkg::IN_U_LSB +: W];
              du_q       <= s_axis_tdata[pors_pkg::IN_DU_LSB +: W];
              phi_q      <= s_axis_tdata[pors_pkg::IN_PHI_LSB +: W];
              peak_q     <= s_axis_tdata[pors_pkg::IN_PEAK_LSB +: W-1];
              peak_ang_q <= pors_pkg::HALF_PI;
              fine_q     <= 1'b0;
              capt_q     <= 1'b0;
            end else if (capt_q) begin
            end else if (capt_hit) begin
              capt_q <= 1'b1;
            end else begin
              if (peak_hit) begin
                peak_q     <= u_q[W-2:0];
                peak_ang_q <= phi_q;
              end
              fine_q   <= fine_next;
              dphase_q <= pors_pkg::DP_STEP;
            end
          end
        end
        pors_pkg::S_RK_INIT: begin
          mphase_q <= pors_pkg::MP_KU;
          stage_q  <= 2'd0;
        end
        pors_pkg::S_MUL_WAIT: begin
          if (mul_done) begin
            unique case (mphase_q)
              pors_pkg::MP_KU: mphase_q <= pors_pkg::MP_SQ;
              pors_pkg::MP_SQ: mphase_q <= pors_pkg::MP_KD;
              default:         mphase_q <= pors_pkg::MP_KU;
            endcase
          end
        end
        pors_pkg::S_ACCUM: begin
          stage_q <= stage_q + 2'd1;
          if (stage_q == 2'd3) begin
            dphase_q <= pors_pkg::DP_SUM_U;
          end
        end
        pors_pkg::S_DIV_USE: begin
          unique case (dphase_q)
            pors_pkg::DP_STEP: ;
            pors_pkg::DP_SUM_U: begin
              u_q      <= pors_pkg::sat_add(u_q, dq_q);
              phi_q    <= pors_pkg::sat_add(phi_q, h_q);
              dphase_q <= pors_pkg::DP_SUM_D;
            end
            default: du_q <= pors_pkg::sat_add(du_q, dq_q);
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pors_pkg::S_IDLE: begin
        if (in_acc) begin
          h_q <= step_q;
        end
      end
      pors_pkg::S_RK_INIT: begin
        us_q <= u_q;
        ds_q <= du_q;
      end
      pors_pkg::S_MUL_WAIT: begin
        if (mul_done) begin
          unique case (mphase_q)
            pors_pkg::MP_KU: ku_q <= mul_p;
            pors_pkg::MP_SQ: t_q  <= mul_p;
            default:         kd_q <= mul_p;
          endcase
        end
      end
      pors_pkg::S_ACC_A: t_q <= pors_pkg::sat_add(t_q, pors_pkg::half(t_q));
      pors_pkg::S_ACC_B: t_q <= pors_pkg::sat_sub(t_q, us_q);
      pors_pkg::S_ACCUM: begin
        unique case (stage_q)
          2'd0: begin
            su_q <= ku_q;
            sd_q <= kd_q;
          end
          2'd1, 2'd2: begin
            su_q <= pors_pkg::sat_add(su_q, pors_pkg::sat_add(ku_q, ku_q));
            sd_q <= pors_pkg::sat_add(sd_q, pors_pkg::sat_add(kd_q, kd_q));
          end
          default: begin
            su_q <= pors_pkg::sat_add(su_q, ku_q);
            sd_q <= pors_pkg::sat_add(sd_q, kd_q);
          end
        endcase
        if (stage_q == 2'd2) begin
          us_q <= pors_pkg::sat_add(u_q, ku_q);
          ds_q <= pors_pkg::sat_add(du_q, kd_q);
        end else begin
          us_q <= pors_pkg::sat_add(u_q, pors_pkg::half(ku_q));
          ds_q <= pors_pkg::sat_add(du_q, pors_pkg::half(kd_q));
        end
      end
      pors_pkg::S_DIV: dneg_q <= div_neg;
      pors_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          dq_q <= dneg_q ? pors_pkg::word_t'(-div_quot) : pors_pkg::word_t'(div_quot);
        end
      end
      pors_pkg::S_DIV_USE: begin
        if (dphase_q == pors_pkg::DP_STEP) begin
          h_q <= dq_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == pors_pkg::S_OUT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pors_pkg::S_OUT && out_free) begin
      m_data_q <= pors_pkg::OUT_DATA_BITS'({peak_ang_q, peak_q, phi_q, du_q, u_q});
      m_user_q <= {fine_q, capt_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[src/pors_checker.sv]
// Port-level checker for the photon orbit RK4 stepper, bound to the top level.
// Depends on pors_pkg and photon_orbit_rk4_stepper_top.
module pors_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic [pors_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  input logic                                  s_axis_tuser,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [pors_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  input logic [1:0]                            m_axis_tuser
);

  localparam int W = pors_pkg::WORD_BITS;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a word was taken");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result word appeared without the block being busy");

  a_load_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid) |-> ##2
    (m_axis_tvalid && m_axis_tdata[W-1:0] == $past(s_axis_tdata[W-1:0], 2) &&
     !m_axis_tuser[0]))
    else $error("load word did not return its start values");

endmodule

bind photon_orbit_rk4_stepper_top pors_checker u_pors_checker (.*);

[tb/sv/photon_orbit_rk4_stepper_top_tb.sv]
// Self-checking testbench for the photon orbit RK4 stepper: directed and random
// load and advance words, each result checked against an in-bench fixed-point orbit model.
// Depends on pors_pkg and photon_orbit_rk4_stepper_top.
module photon_orbit_rk4_stepper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC          = 36;
  localparam longint FINE_STEPS    = 25;
  localparam longint Q_MAX         = 64'sd140737488355327;
  localparam longint Q_MIN         = -64'sd140737488355328;
  localparam int     LIMIT_CYCLES  = 1000000;
  localparam int     SETTLE_CYCLES = 300;

  localparam logic [63:0] QUARTER_TURN_Q63 = 64'hC90FDAA22168C235;
  localparam longint HALF_PI_Q =
    longint'((QUARTER_TURN_Q63 + (64'd1 << (62 - FRAC))) >> (63 - FRAC));

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam pors_pkg::cfg_idx_t CFG_SPARE = pors_pkg::cfg_idx_t'(3);

  typedef struct {
    pors_pkg::word_t  inv_radius;
    pors_pkg::word_t  slope;
    pors_pkg::word_t  angle;
    pors_pkg::uword_t closest_u;
    pors_pkg::word_t  closest_angle;
    logic             captured;
    logic             fine_mode;
  } orbit_word_t;

  logic                                  clk_i;
  logic                                  rst_ni        = 1'b0;
  logic                                  s_axis_tvalid = 1'b0;
  logic                                  s_axis_tready;
  logic [pors_pkg::IN_DATA_BITS-1:0]     s_axis_tdata  = '0;
  logic                                  s_axis_tuser  = 1'b0;
  logic                                  m_axis_tvalid;
  logic                                  m_axis_tready = 1'b1;
  logic [pors_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata;
  logic [1:0]                            m_axis_tuser;
  logic                                  cfg_valid_i   = 1'b0;
  logic                                  cfg_ready_o;
  pors_pkg::cfg_idx_t                    cfg_index_i   = '0;
  logic [pors_pkg::WORD_BITS-1:0]        cfg_data_i    = '0;

  longint orb_u, orb_slope, orb_angle, orb_peak_u, orb_peak_angle;
  bit     orb_fine, orb_captured;
  longint cfg_step, cfg_limit, cfg_thr;

  orbit_word_t pending_orbits[$];
  orbit_word_t want_r, got_r;
  int          fail_count  = 0;
  int          stall_left  = 0;
  int          cycle_count = 0;
  bit          idle_on     = 1'b0;

  photon_orbit_rk4_stepper_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sext48(logic [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

  function automatic longint q_clamp(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint q_add(longint a, longint b);
    return q_clamp(a + b);
  endfunction

  function automatic longint q_half(longint x);
    return x / 2;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic         neg;
    logic [127:0] prod;
    logic [127:0] lim;
    neg  = (a < 0) != (b < 0);
    prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
    lim  = neg ? 128'(Q_MAX) + 128'd1 : 128'(Q_MAX);
    if (prod > lim) return neg ? Q_MIN : Q_MAX;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint q_div6(longint s);
    longint unsigned m;
    m = s < 0 ? -s : s;
    m = (m + 3) / 6;
    return s < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Right-hand side of u'' = 1.5u^2 - u.
  function automatic longint orbit_accel(longint u);
    longint sq;
    sq = q_mul(u, u);
    return q_clamp(q_add(sq, q_half(sq)) - u);
  endfunction

  function automatic void rk4_advance(longint h);
    longint k1u, k1d, k2u, k2d, k3u, k3d, k4u, k4d;
    longint u2, d2, u3, d3, u4, d4, su, sd;
    k1u = q_mul(h, orb_slope);
    k1d = q_mul(h, orbit_accel(orb_u));
    u2  = q_add(orb_u, q_half(k1u));
    d2  = q_add(orb_slope, q_half(k1d));
    k2u = q_mul(h, d2);
    k2d = q_mul(h, orbit_accel(u2));
    u3  = q_add(orb_u, q_half(k2u));
    d3  = q_add(orb_slope, q_half(k2d));
    k3u = q_mul(h, d3);
    k3d = q_mul(h, orbit_accel(u3));
    u4  = q_add(orb_u, k3u);
    d4  = q_add(orb_slope, k3d);
    k4u = q_mul(h, d4);
    k4d = q_mul(h, orbit_accel(u4));
    su  = q_add(q_add(q_add(k1u, q_add(k2u, k2u)), q_add(k3u, k3u)), k4u);
    sd  = q_add(q_add(q_add(k1d, q_add(k2d, k2d)), q_add(k3d, k3d)), k4d);
    orb_angle = q_add(orb_angle, h);
    orb_u     = q_add(orb_u, q_div6(su));
    orb_slope = q_add(orb_slope, q_div6(sd));
  endfunction

  function automatic orbit_word_t predict_orbit(logic op, longint su, longint sdu,
                                                longint sphi, longint speak);
    orbit_word_t w;
    longint      h;
    if (op == OP_LOAD) begin
      orb_u          = sext48(su[47:0]);
      orb_slope      = sext48(sdu[47:0]);
      orb_angle      = sext48(sphi[47:0]);
      orb_peak_u     = {17'd0, speak[46:0]};
      orb_peak_angle = HALF_PI_Q;
      orb_fine       = 1'b0;
      orb_captured   = 1'b0;
    end else if (!orb_captured) begin
      if (orb_u > cfg_limit) begin
        orb_captured = 1'b1;
      end else begin
        if (orb_u > orb_peak_u) begin
          orb_peak_u     = orb_u;
          orb_peak_angle = orb_angle;
        end
        if (!orb_fine && orb_u > cfg_thr) begin
          orb_fine = 1'b1;
        end else if (orb_fine && orb_u < cfg_thr) begin
          orb_fine = 1'b0;
        end
        h = orb_fine ? cfg_step / FINE_STEPS : cfg_step;
        rk4_advance(h);
      end
    end
    w.inv_radius    = orb_u[47:0];
    w.slope         = orb_slope[47:0];
    w.angle         = orb_angle[47:0];
    w.closest_u     = orb_peak_u[46:0];
    w.closest_angle = orb_peak_angle[47:0];
    w.captured      = orb_captured;
    w.fine_mode     = orb_fine;
    return w;
  endfunction

  function automatic longint q_of(real r);
    return longint'(r * 68719476736.0);
  endfunction

  function automatic longint rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return sext48(r[47:0]);
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    longint unsigned span, r;
    if (hi <= lo) return lo;
    span = hi - lo;
    r    = {$urandom, $urandom};
    return lo + longint'(r % (span + 1));
  endfunction

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_orbits.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("output word with none pending: %h", m_axis_tdata);
        end
      end else begin
        want_r = pending_orbits.pop_front();
        got_r.inv_radius    = m_axis_tdata[47:0];
        got_r.slope         = m_axis_tdata[95:48];
        got_r.angle         = m_axis_tdata[143:96];
        got_r.closest_u     = m_axis_tdata[190:144];
        got_r.closest_angle = m_axis_tdata[238:191];
        got_r.captured      = m_axis_tuser[0];
        got_r.fine_mode     = m_axis_tuser[1];
        check_field("inv_radius", want_r.inv_radius, got_r.inv_radius);
        check_field("inv_radius_slope", want_r.slope, got_r.slope);
        check_field("angle", want_r.angle, got_r.angle);
        check_field("closest_u", 48'(want_r.closest_u), 48'(got_r.closest_u));
        check_field("closest_angle", want_r.closest_angle, got_r.closest_angle);
        check_field("captured", 48'(want_r.captured), 48'(got_r.captured));
        check_field("fine_mode", 48'(want_r.fine_mode), 48'(got_r.fine_mode));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_word(logic op, longint su, longint sdu, longint sphi, longint speak);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, speak[46:0], sphi[47:0], sdu[47:0], su[47:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_orbits.push_back(predict_orbit(op, su, sdu, sphi, speak));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_orbits.size() != 0);
  endtask

  task automatic cfg_write(pors_pkg::cfg_idx_t idx, logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pors_pkg::CFG_STEP_ANGLE:     cfg_step  = sext48(data);
      pors_pkg::CFG_CAPTURE_LIMIT:  cfg_limit = {17'd0, data[46:0]};
      pors_pkg::CFG_FINE_THRESHOLD: cfg_thr   = {17'd0, data[46:0]};
      default: ;
    endcase
  endtask

  task automatic apply_settings(longint step, longint limit, longint thr);
    wait_results_drained();
    cfg_write(pors_pkg::CFG_STEP_ANGLE, step[47:0]);
    cfg_write(pors_pkg::CFG_CAPTURE_LIMIT, limit[47:0]);
    cfg_write(pors_pkg::CFG_FINE_THRESHOLD, thr[47:0]);
    cfg_write(CFG_SPARE, rand_word());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_after_reset();
    push_word(OP_ADVANCE, 0, 0, 0, 0);
    push_word(OP_ADVANCE, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
    push_word(OP_LOAD, 0, 0, 0, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
  endtask

  task automatic test_capture_and_freeze();
    push_word(OP_LOAD, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
    push_word(OP_LOAD, cfg_limit, 0, 0, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
  endtask

  task automatic test_negative_extremes();
    push_word(OP_LOAD, Q_MIN, Q_MAX, Q_MIN, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
  endtask

  task automatic test_fine_step_switch();
    push_word(OP_LOAD, cfg_thr, 0, 0, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
    push_word(OP_LOAD, cfg_thr + 1, q_of(0.5), 0, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
    push_word(OP_ADVANCE, 0, 0, 0, 0);
  endtask

  // Mostly load-then-advance runs that start near the fine threshold and the
  // capture limit, mixed with unstructured words.
  task automatic test_orbit_phase(longint step, longint limit, longint thr,
                                  int n_words, bit with_idle);
    int     sent;
    longint lo, hi, u0, peak0;
    apply_settings(step, limit, thr);
    sent = 0;
    lo   = (thr < limit ? thr : limit) - q_of(0.1);
    hi   = limit + q_of(0.05);
    if (hi > thr + q_of(1.5)) hi = thr + q_of(1.5);
    while (sent < n_words) begin
      idle_on = with_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 2) begin
        push_word($urandom_range(0, 1) ? OP_ADVANCE : OP_LOAD,
                  rand_word(), rand_word(), rand_word(), rand_word());
        sent++;
      end else begin
        u0    = q_clamp(rand_between(lo, hi));
        peak0 = $urandom_range(0, 1) ? 0 : rand_between(0, u0 > 0 ? u0 : 0);
        push_word(OP_LOAD, u0, rand_between(-q_of(0.5), q_of(0.5)),
                  rand_between(-q_of(4.0), q_of(4.0)), peak0);
        sent++;
        repeat ($urandom_range(4, 25)) begin
          push_word(OP_ADVANCE, rand_word(), rand_word(), rand_word(), rand_word());
          sent++;
        end
        if ($urandom_range(0, 7) == 0) begin
          wait_results_drained();
        end
      end
    end
  endtask

  initial begin
    cfg_step  = sext48(pors_pkg::STEP_RESET);
    cfg_limit = {17'd0, pors_pkg::LIMIT_RESET};
    cfg_thr   = {17'd0, pors_pkg::THR_RESET};
    void'(predict_orbit(OP_LOAD, 0, 0, 0, 0));
    orb_peak_angle = 0;
    repeat (7) @(posedge clk_i);
    rst_ni  <= 1'b1;
    idle_on = 1'b1;

    test_after_reset();
    test_capture_and_freeze();
    test_negative_extremes();
    test_fine_step_switch();

    test_orbit_phase(-q_of(0.02), q_of(0.6), q_of(0.2), 90, 1'b1);
    test_orbit_phase(Q_MIN, Q_MAX, 0, 90, 1'b1);
    test_orbit_phase(0, 0, Q_MAX, 90, 1'b1);
    begin
      longint thr_r;
      thr_r = rand_between(q_of(0.05), q_of(0.5));
      test_orbit_phase(-rand_between(0, q_of(0.1)), thr_r + rand_between(q_of(0.05), thr_r),
                       thr_r, 90, 1'b1);
    end
    test_orbit_phase(-q_of(0.05), q_of(0.9), q_of(0.3), 90, 1'b0);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
